FILE: design/soau_pkg.sv
// soau_pkg: shared types and constants of the segmented operand access unit
// used by the register file, the top level and the port checker
`default_nettype none

package soau_pkg;

   // default parameter values
   localparam int DEF_NUM_SEGMENTS = 8;
   localparam int DEF_NUM_REGS     = 32;
   localparam int DEF_MEM_BYTES    = 65536;
   localparam int DEF_ACCESS_BYTES = 4;

   // fixed field widths
   localparam int WORD_BYTES  = 4;
   localparam int REG_IDX_W   = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CNT_W       = 3;
   // reciprocal of the smallest memory size (256) needs 25 bits
   localparam int RECIP_W     = 25;
   localparam int PROD_W      = 16 + RECIP_W;

   // operand kinds in bits 31..24 of the operand word
   localparam logic [7:0] KIND_REG = 8'd1;
   localparam logic [7:0] KIND_IMM = 8'd2;
   localparam logic [7:0] KIND_MEM = 8'd3;

   // transaction direction
   localparam logic MODE_WRITE = 1'b1;

   // dedicated registers of a memory access
   localparam logic [REG_IDX_W-1:0] REG_LAR = 5'd4;
   localparam logic [REG_IDX_W-1:0] REG_MAR = 5'd5;
   localparam logic [REG_IDX_W-1:0] REG_MBR = 5'd6;

   // register file write port
   typedef struct packed {
      logic                 en;
      logic [REG_IDX_W-1:0] index;
      logic [31:0]          data;
   } rf_write_type;

endpackage

`default_nettype wire

FILE: design/soau_regfile.sv
// soau_regfile: general register file, one read port and one write port
// depends on soau_pkg for the write port struct
`default_nettype none

module soau_regfile
   import soau_pkg::*;
#(
   parameter int NUM_REGS = DEF_NUM_REGS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [REG_IDX_W-1:0] rd_index,
   output logic      [31:0]          rd_data,
   input  wire rf_write_type         wr
);

   localparam int IDX_W = $clog2(NUM_REGS);

   logic [31:0] regs_ff [NUM_REGS];
   logic        rd_in_range;
   logic        wr_in_range;

   // indexes past the implemented registers read zero and drop writes
   assign rd_in_range = {1'b0, rd_index} < (REG_IDX_W + 1)'(NUM_REGS);
   assign wr_in_range = {1'b0, wr.index} < (REG_IDX_W + 1)'(NUM_REGS);
   assign rd_data     = rd_in_range ? regs_ff[rd_index[IDX_W-1:0]] : 32'd0;

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= 32'd0;
         end
      end else if (wr.en && wr_in_range) begin
         regs_ff[wr.index[IDX_W-1:0]] <= wr.data;
      end
   end

endmodule

`default_nettype wire

FILE: design/soau_byte_ram.sv
// soau_byte_ram: byte-wide data memory, one port, registered read data
// no dependencies
`default_nettype none

module soau_byte_ram #(
   parameter  int MEM_BYTES = 65536,
   localparam int ADDR_W    = $clog2(MEM_BYTES)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [7:0]        wdata,
   output logic      [7:0]        rdata
);

   logic [7:0] mem_ff [MEM_BYTES];
   logic [7:0] rdata_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

FILE: design/segmented_operand_access_unit.sv
// Segmented operand access unit. One transaction reads or writes one operand
// (register, 16-bit immediate, segmented memory word or none) through a small
// sequencer around a shared register file port and a byte-wide memory port.
// After reset the data memory is cleared one byte a cycle with req_stall high;
// descriptor writes are taken at any time. A transaction on a register,
// immediate or none operand goes through the execute and finish states. A
// memory operand that faults ends after the segment check; one that passes goes
// through address add, segment check, a reciprocal multiply and subtract that
// reduce the physical address to a memory index, then one byte a cycle over the
// single memory port, and for a read a drain step. A finished result waits in an
// output register, so the next transaction may be accepted before the result is
// taken.
// depends on soau_pkg, soau_regfile, soau_byte_ram
`default_nettype none

module segmented_operand_access_unit
   import soau_pkg::*;
#(
   parameter int NUM_SEGMENTS = DEF_NUM_SEGMENTS,
   parameter int NUM_REGS     = DEF_NUM_REGS,
   parameter int MEM_BYTES    = DEF_MEM_BYTES,
   parameter int ACCESS_BYTES = DEF_ACCESS_BYTES
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_mode,
   input  wire logic [31:0]            req_operand_word,
   input  wire logic [31:0]            req_write_value,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [31:0]            rsp_read_value,
   output logic                        rsp_segment_fault,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_wdata
);

   localparam int MEM_ADDR_W = $clog2(MEM_BYTES);
   localparam int SEG_IDX_W  = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
   localparam int PRE_SHIFT  = 8 * (WORD_BYTES - ACCESS_BYTES);
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << 32) + 64'(MEM_BYTES) - 64'd1) / 64'(MEM_BYTES);
   localparam logic [RECIP_W-1:0]    RECIP     = RECIP_FULL[RECIP_W-1:0];
   localparam logic [16:0]           MEM_SIZE  = 17'(MEM_BYTES);
   localparam logic [MEM_ADDR_W-1:0] MEM_MAX   = MEM_ADDR_W'(MEM_BYTES - 1);
   localparam logic [CNT_W-1:0]      LAST_BYTE = CNT_W'(ACCESS_BYTES - 1);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_CHECK,
      S_MOD_MUL,
      S_MOD_SUB,
      S_XFER,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type              state_ff, state_in;
   logic                   mode_ff, mode_in;
   logic [31:0]            word_ff, word_in;
   logic [31:0]            val_ff, val_in;
   logic [31:0]            logical_ff, logical_in;
   logic [15:0]            addr_ff, addr_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic [MEM_ADDR_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   pend_ff, pend_in;
   logic [31:0]            acc_ff, acc_in;
   logic [31:0]            sh_ff, sh_in;
   logic [31:0]            result_ff, result_in;
   logic                   fault_ff, fault_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [31:0]            rsp_value_ff, rsp_value_in;
   logic                   rsp_fault_ff, rsp_fault_in;
   logic [31:0]            seg_desc_ff [NUM_SEGMENTS];

   rf_write_type           rf_wr;
   logic [31:0]            rf_rd_data;
   logic                   ram_we;
   logic [MEM_ADDR_W-1:0]  ram_addr;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;

   logic [7:0]             seg;
   logic [15:0]            off;
   logic                   seg_ok;
   logic [31:0]            desc;
   logic                   chk_fault;
   logic [8:0]             quot;
   logic [16:0]            quot_mul;
   logic [16:0]            rem;
   logic [15:0]            addr_step;
   logic [31:0]            acc_next;

   // register file and data memory
   soau_regfile #(
      .NUM_REGS (NUM_REGS)
   ) u_regfile (
      .clock    (clock),
      .reset    (reset),
      .rd_index (word_ff[REG_IDX_W-1:0]),
      .rd_data  (rf_rd_data),
      .wr       (rf_wr)
   );

   soau_byte_ram #(
      .MEM_BYTES (MEM_BYTES)
   ) u_byte_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // segment descriptors
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SEGMENTS; i++) begin
            seg_desc_ff[i] <= 32'd0;
         end
      end else if (csr_valid && csr_ready &&
                   (csr_index < CSR_INDEX_W'(NUM_SEGMENTS))) begin
         seg_desc_ff[csr_index[SEG_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // segment check on the logical address
   assign seg       = logical_ff[23:16];
   assign off       = logical_ff[15:0];
   assign seg_ok    = seg < 8'(NUM_SEGMENTS);
   assign desc      = seg_ok ? seg_desc_ff[seg[SEG_IDX_W-1:0]] : 32'd0;
   assign chk_fault = !seg_ok || (off >= desc[15:0]);

   // physical address modulo memory size, from the registered product
   assign quot     = prod_ff[PROD_W-1:32];
   assign quot_mul = 17'(quot * MEM_SIZE);
   assign rem      = {1'b0, addr_ff} - quot_mul;

   // next byte: address wraps at 16 bits, index wraps at memory size
   assign addr_step = addr_ff + 16'd1;
   assign acc_next  = {acc_ff[23:0], ram_rdata};

   assign req_stall         = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_segment_fault = rsp_fault_ff;

   // sequencer next state
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      word_in      = word_ff;
      val_in       = val_ff;
      logical_in   = logical_ff;
      addr_in      = addr_ff;
      prod_in      = prod_ff;
      idx_in       = idx_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      acc_in       = acc_ff;
      sh_in        = sh_ff;
      result_in    = result_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_fault_in = rsp_fault_ff;
      rf_wr        = '0;
      ram_we       = 1'b0;
      ram_addr     = idx_ff;
      ram_wdata    = 8'd0;

      // output register drains independently
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            idx_in = idx_ff + MEM_ADDR_W'(1);
            if (idx_ff == MEM_MAX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               word_in   = req_operand_word;
               val_in    = req_write_value;
               result_in = 32'd0;
               fault_in  = 1'b0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_FINISH;
            case (word_ff[31:24])
               KIND_REG: begin
                  if (mode_ff == MODE_WRITE) begin
                     rf_wr = '{en: 1'b1, index: word_ff[REG_IDX_W-1:0], data: val_ff};
                  end else begin
                     result_in = rf_rd_data;
                  end
               end
               KIND_IMM: begin
                  if (mode_ff != MODE_WRITE) begin
                     result_in = {16'd0, word_ff[15:0]};
                  end
               end
               KIND_MEM: begin
                  logical_in = rf_rd_data + {16'd0, word_ff[23:8]};
                  rf_wr      = '{en: 1'b1, index: REG_LAR, data: logical_in};
                  state_in   = S_CHECK;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_CHECK: begin
            if (chk_fault) begin
               fault_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               addr_in  = desc[31:16] + off;
               rf_wr    = '{en: 1'b1, index: REG_MAR,
                            data: (32'(ACCESS_BYTES) << 16) | {16'd0, addr_in}};
               state_in = S_MOD_MUL;
            end
         end
         S_MOD_MUL: begin
            prod_in = PROD_W'(addr_ff) * PROD_W'(RECIP);
            if (mode_ff == MODE_WRITE) begin
               rf_wr = '{en: 1'b1, index: REG_MBR, data: val_ff};
            end
            sh_in    = val_ff << PRE_SHIFT;
            cnt_in   = '0;
            acc_in   = 32'd0;
            pend_in  = 1'b0;
            state_in = S_MOD_SUB;
         end
         S_MOD_SUB: begin
            idx_in   = rem[MEM_ADDR_W-1:0];
            state_in = S_XFER;
         end
         S_XFER: begin
            if (mode_ff == MODE_WRITE) begin
               ram_we    = 1'b1;
               ram_wdata = sh_ff[31:24];
               sh_in     = sh_ff << 8;
            end else begin
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_next;
            end
            addr_in = addr_step;
            if ((addr_step == 16'd0) || (idx_ff == MEM_MAX)) begin
               idx_in = '0;
            end else begin
               idx_in = idx_ff + MEM_ADDR_W'(1);
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == LAST_BYTE) begin
               state_in = (mode_ff == MODE_WRITE) ? S_FINISH : S_DRAIN;
            end
         end
         S_DRAIN: begin
            rf_wr     = '{en: 1'b1, index: REG_MBR, data: acc_next};
            acc_in    = acc_next;
            result_in = acc_next;
            pend_in   = 1'b0;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = result_ff;
               rsp_fault_in = fault_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, datapath and output registers
   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      word_ff      <= word_in;
      val_ff       <= val_in;
      logical_ff   <= logical_in;
      addr_ff      <= addr_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      sh_ff        <= sh_in;
      result_ff    <= result_in;
      fault_ff     <= fault_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fault_ff <= rsp_fault_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/soau_checker.sv
// soau_checker: port-level assertions for the segmented operand access unit
// depends on soau_pkg; bound to segmented_operand_access_unit below
`default_nettype none

module soau_checker
   import soau_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        req_mode,
   input wire logic [31:0] req_operand_word,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [31:0] rsp_read_value,
   input wire logic        rsp_segment_fault
);

   logic       push;
   logic       pop;
   logic [1:0] cnt_ff;
   logic [1:0] write_q_ff, write_q_in;
   logic [1:0] mem_q_ff, mem_q_in;
   logic [1:0] slot;

   assign push = req_valid && !req_stall;
   assign pop  = rsp_valid && !rsp_stall;
   assign slot = pop ? (cnt_ff - 2'd1) : cnt_ff;

   // next direction and kind of transactions awaiting their result
   always_comb begin
      write_q_in = write_q_ff;
      mem_q_in   = mem_q_ff;
      if (pop) begin
         write_q_in[0] = write_q_ff[1];
         mem_q_in[0]   = mem_q_ff[1];
      end
      if (push && (slot != 2'd2)) begin
         write_q_in[slot[0]] = (req_mode == MODE_WRITE);
         mem_q_in[slot[0]]   = (req_operand_word[31:24] == KIND_MEM);
      end
   end

   // track direction and kind of transactions awaiting their result
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= 2'd0;
         write_q_ff <= 2'b00;
         mem_q_ff   <= 2'b00;
      end else begin
         cnt_ff     <= cnt_ff + 2'(push) - 2'(pop);
         write_q_ff <= write_q_in;
         mem_q_ff   <= mem_q_in;
      end
   end

   // every result belongs to an accepted transaction
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("result without an outstanding transaction");

   // a fault always returns a zero value
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_segment_fault |-> rsp_read_value == 32'd0)
      else $error("faulted transaction returned nonzero data");

   // only memory operands can fault
   a_fault_mem_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cnt_ff != 2'd0) && !mem_q_ff[0] |-> !rsp_segment_fault)
      else $error("fault on a non-memory operand");

   // writes return zero
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (cnt_ff != 2'd0) && write_q_ff[0] |-> rsp_read_value == 32'd0)
      else $error("write transaction returned nonzero data");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_value) &&
                                 $stable(rsp_segment_fault))
      else $error("stalled result changed");

endmodule

bind segmented_operand_access_unit soau_checker u_soau_checker (.*);

`default_nettype wire
